// File: design/bsal_pkg.sv
// shared types and constants of the bar synced audio looper
package bsal_pkg;

    localparam int LEN_W     = 20;
    localparam int STATE_W   = 3;
    localparam int MODE_W    = 2;
    localparam int SKIP_W    = 8;
    localparam int GAIN_W    = 16;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 20;

    localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STATE_W-1:0] ST_ARMED = 3'd1;
    localparam logic [STATE_W-1:0] ST_REC   = 3'd2;
    localparam logic [STATE_W-1:0] ST_STOP  = 3'd3;
    localparam logic [STATE_W-1:0] ST_PLAY  = 3'd4;
    localparam logic [STATE_W-1:0] ST_OVDB  = 3'd5;

    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CMD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_BAR_SYNC  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SKIP_BARS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REVERSE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY  = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_UNITY    = 16'd16384;
    localparam logic [LEN_W-1:0]  CAPACITY_INIT = 20'd524288;

    typedef struct packed {
        logic              bar_sync;
        logic [SKIP_W-1:0] skip_bars;
        logic [GAIN_W-1:0] gain;
        logic              reverse;
        logic [LEN_W-1:0]  capacity;
    } cfg_t;

    // per item work handed from the control stage to the data stage
    typedef struct packed {
        logic               wr;
        logic               ovd;
        logic               snd;
        logic [LEN_W-1:0]   addr;
        logic [STATE_W-1:0] state;
        logic [LEN_W-1:0]   head;
        logic [LEN_W-1:0]   rep_len;
    } op_t;

endpackage

// File: design/bsal_ram.sv
// generic single write port ram with registered read
module bsal_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 524288
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/bsal_ctrl.sv
// looper state machine, head and length bookkeeping, memory access decode
module bsal_ctrl #(
    parameter int MAX_FRAMES = 524288
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  logic [bsal_pkg::MODE_W-1:0]   mode,
    input  logic                          bar,
    input  logic                          run,
    input  logic [bsal_pkg::STATE_W-1:0]  new_state,
    input  bsal_pkg::cfg_t                cfg,
    output bsal_pkg::op_t                 op
);

    localparam int LW = bsal_pkg::LEN_W;
    localparam logic [24:0] MAX_W = 25'(MAX_FRAMES);

    logic [bsal_pkg::STATE_W-1:0] state_reg, state_next;
    logic [LW-1:0]                head_reg, head_next;
    logic [LW-1:0]                rep_reg, rep_next;
    logic [LW-1:0]                frames_reg, frames_next;
    logic                         os_set_reg, os_set_next;
    logic [LW-1:0]                os_reg, os_next;
    logic [bsal_pkg::SKIP_W-1:0]  dbc_reg, dbc_next;

    logic [LW-1:0] cap_now;
    assign cap_now = (25'(cfg.capacity) > MAX_W) ? LW'(MAX_W) : cfg.capacity;

    always_comb begin
        logic          do_rec;
        logic [LW-1:0] rec_base;
        logic [LW-1:0] len;
        logic [LW-1:0] h;
        logic [LW-1:0] ri;
        logic [LW-1:0] hn;
        logic          end_ovd;
        logic          cmd_done;

        state_next  = state_reg;
        head_next   = head_reg;
        rep_next    = rep_reg;
        frames_next = frames_reg;
        os_set_next = os_set_reg;
        os_next     = os_reg;
        dbc_next    = dbc_reg;
        op.wr       = 1'b0;
        op.ovd      = 1'b0;
        op.snd      = 1'b0;
        op.addr     = '0;
        do_rec      = 1'b0;
        rec_base    = head_reg;
        len         = frames_reg;
        h           = (head_reg < len) ? head_reg : '0;
        ri          = cfg.reverse ? (len - LW'(1) - h) : h;
        hn          = ((LW+1)'(h) + (LW+1)'(1) == (LW+1)'(len)) ? '0 : (h + LW'(1));
        end_ovd     = os_set_reg && (h > (len >> 1))
                      && ((LW+1)'(hn) <= ((LW+1)'(os_reg) + (LW+1)'(1)));
        cmd_done    = 1'b0;

        case (mode)
            bsal_pkg::MODE_TICK: begin
                case (state_reg)
                    bsal_pkg::ST_ARMED: begin
                        if (cfg.bar_sync && !(run && bar)) begin
                            dbc_next = dbc_reg;
                        end else if (cfg.bar_sync && (dbc_reg < cfg.skip_bars)) begin
                            dbc_next = dbc_reg + 8'd1;
                        end else begin
                            state_next = bsal_pkg::ST_REC;
                            rec_base   = '0;
                            do_rec     = 1'b1;
                        end
                    end
                    bsal_pkg::ST_REC, bsal_pkg::ST_STOP: begin
                        if (head_reg >= cap_now
                            || (state_reg == bsal_pkg::ST_STOP && bar)) begin
                            frames_next = head_reg;
                            rep_next    = head_reg;
                            state_next  = bsal_pkg::ST_PLAY;
                            head_next   = '0;
                        end else begin
                            do_rec = 1'b1;
                        end
                    end
                    bsal_pkg::ST_PLAY, bsal_pkg::ST_OVDB: begin
                        if (len != '0) begin
                            op.snd    = 1'b1;
                            op.addr   = ri;
                            head_next = hn;
                            if (state_reg == bsal_pkg::ST_OVDB) begin
                                op.wr  = 1'b1;
                                op.ovd = 1'b1;
                                if (end_ovd) begin
                                    state_next = bsal_pkg::ST_PLAY;
                                end
                            end
                        end
                    end
                    default: begin
                        state_next = state_reg;
                    end
                endcase
            end
            bsal_pkg::MODE_CMD: begin
                if (new_state <= bsal_pkg::ST_OVDB) begin
                    if (new_state == bsal_pkg::ST_ARMED) begin
                        head_next   = '0;
                        rep_next    = '0;
                        frames_next = '0;
                        dbc_next    = '0;
                    end
                    if (new_state == bsal_pkg::ST_PLAY && state_reg == bsal_pkg::ST_REC) begin
                        if (cfg.bar_sync) begin
                            state_next = bsal_pkg::ST_STOP;
                            cmd_done   = 1'b1;
                        end else begin
                            frames_next = head_reg;
                            rep_next    = head_reg;
                            head_next   = '0;
                        end
                    end
                    if (!cmd_done) begin
                        if (new_state == bsal_pkg::ST_OVDB) begin
                            os_set_next = 1'b1;
                            os_next     = head_reg;
                        end
                        if (new_state == bsal_pkg::ST_IDLE) begin
                            head_next   = '0;
                            os_set_next = 1'b0;
                        end
                        state_next = new_state;
                    end
                end
            end
            bsal_pkg::MODE_CLEAR: begin
                head_next   = '0;
                rep_next    = '0;
                frames_next = '0;
                os_set_next = 1'b0;
            end
            default: begin
                state_next = state_reg;
            end
        endcase

        if (do_rec) begin
            if (rec_base < cap_now) begin
                op.wr     = 1'b1;
                op.addr   = rec_base;
                head_next = rec_base + LW'(1);
            end else begin
                head_next = rec_base;
            end
            rep_next = head_next;
        end

        op.state   = state_next;
        op.head    = head_next;
        op.rep_len = rep_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bsal_pkg::ST_IDLE;
            head_reg   <= '0;
            rep_reg    <= '0;
            frames_reg <= '0;
            os_set_reg <= 1'b0;
            os_reg     <= '0;
            dbc_reg    <= '0;
        end else if (in_fire) begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            rep_reg    <= rep_next;
            frames_reg <= frames_next;
            os_set_reg <= os_set_next;
            os_reg     <= os_next;
            dbc_reg    <= dbc_next;
        end
    end

endmodule

// File: design/bsal_datapath.sv
// data stage: memory read forwarding, gain, overdub sum and result register
module bsal_datapath #(
    parameter int SAMPLE_BITS = 24,
    parameter int OUT_W = 96
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_fire,
    input  bsal_pkg::op_t                  in_op,
    input  logic [SAMPLE_BITS-1:0]         in_left,
    input  logic [SAMPLE_BITS-1:0]         in_right,
    input  logic [bsal_pkg::GAIN_W-1:0]    gain,
    output logic                           stage_ready,
    input  logic [2*SAMPLE_BITS-1:0]       rd_data,
    output logic                           wr_en,
    output logic [bsal_pkg::LEN_W-1:0]     wr_addr,
    output logic [2*SAMPLE_BITS-1:0]       wr_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_W-1:0]               m_tdata
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + bsal_pkg::GAIN_W + 1;
    localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    function automatic logic [SB-1:0] sat_gain(input logic [SB+2:0] v);
        logic [3:0] top;
        top = v[SB+2:SB-1];
        if (&top || ~|top) begin
            return v[SB-1:0];
        end else if (v[SB+2]) begin
            return S_MIN;
        end else begin
            return S_MAX;
        end
    endfunction

    function automatic logic [SB-1:0] sat_sum(input logic [SB:0] v);
        if (v[SB] == v[SB-1]) begin
            return v[SB-1:0];
        end else if (v[SB]) begin
            return S_MIN;
        end else begin
            return S_MAX;
        end
    endfunction

    logic                b_valid_reg;
    bsal_pkg::op_t       b_op_reg;
    logic [SB-1:0]       b_left_reg, b_right_reg;
    logic                fwd_reg;
    logic [2*SB-1:0]     fwd_data_reg;
    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_data_reg;

    logic                out_ready, b_fire;
    logic [SB-1:0]       mem_l, mem_r;
    logic signed [PW-1:0] prod_l, prod_r;
    logic [PW-1:0]       rnd_l, rnd_r;
    logic [SB-1:0]       play_l, play_r;
    logic [SB-1:0]       new_l, new_r;

    assign out_ready   = !m_valid_reg || m_tready;
    assign b_fire      = b_valid_reg && out_ready;
    assign stage_ready = !b_valid_reg || out_ready;

    assign mem_l = fwd_reg ? fwd_data_reg[SB-1:0]    : rd_data[SB-1:0];
    assign mem_r = fwd_reg ? fwd_data_reg[2*SB-1:SB] : rd_data[2*SB-1:SB];

    assign prod_l = $signed(mem_l) * $signed({1'b0, gain});
    assign prod_r = $signed(mem_r) * $signed({1'b0, gain});
    assign rnd_l  = prod_l + PW'(8192);
    assign rnd_r  = prod_r + PW'(8192);
    assign play_l = b_op_reg.snd ? sat_gain(rnd_l[PW-1:14]) : '0;
    assign play_r = b_op_reg.snd ? sat_gain(rnd_r[PW-1:14]) : '0;

    assign new_l = b_op_reg.ovd
                 ? sat_sum({mem_l[SB-1], mem_l} + {b_left_reg[SB-1], b_left_reg})
                 : b_left_reg;
    assign new_r = b_op_reg.ovd
                 ? sat_sum({mem_r[SB-1], mem_r} + {b_right_reg[SB-1], b_right_reg})
                 : b_right_reg;

    assign wr_en   = b_fire && b_op_reg.wr;
    assign wr_addr = b_op_reg.addr;
    assign wr_data = {new_r, new_l};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end else begin
            if (in_fire) begin
                b_valid_reg <= 1'b1;
                fwd_reg     <= wr_en && (b_op_reg.addr == in_op.addr);
            end else if (b_fire) begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            b_op_reg     <= in_op;
            b_left_reg   <= in_left;
            b_right_reg  <= in_right;
            fwd_data_reg <= wr_data;
        end
        if (b_fire) begin
            m_data_reg <= OUT_W'({b_op_reg.rep_len, b_op_reg.head, b_op_reg.state,
                                  play_r, play_l});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: design/bar_synced_audio_looper.sv
// top level of the bar synced stereo looper with overdub
// result: an accepted item passes the data stage register, then the output register
// throughput: one item per cycle unless output stalls; ram read at accept, written at stage exit
// reset: synchronous active low aresetn clears state to idle, head and lengths to zero,
//   and loads the register defaults; loop memory is not cleared and reads undefined until written
module bar_synced_audio_looper #(
    parameter int MAX_FRAMES  = 524288,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // sample_left, sample_right, bar_boundary, transport_running, new_state, zero fill
    input  logic [((2*SAMPLE_BITS+12)/8)*8-1:0]        s_tdata,
    // mode
    input  logic [bsal_pkg::MODE_W-1:0]                s_tuser,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // play_left, play_right, loop_state, head_position, recorded_length, zero fill
    output logic [((2*SAMPLE_BITS+50)/8)*8-1:0]        m_tdata,
    input  logic                                       cfg_wr_en,
    input  logic [bsal_pkg::REG_IDX_W-1:0]             cfg_index,
    input  logic [bsal_pkg::CFG_W-1:0]                 cfg_wdata
);

    localparam int SB     = SAMPLE_BITS;
    localparam int OUT_W  = ((2*SAMPLE_BITS+50)/8)*8;
    localparam int ADDR_W = $clog2(MAX_FRAMES);

    bsal_pkg::cfg_t cfg_reg;
    bsal_pkg::op_t  op;

    logic                        in_fire, stage_ready;
    logic [SB-1:0]               in_left, in_right;
    logic [2*SB-1:0]             rd_data, wr_data;
    logic                        wr_en;
    logic [bsal_pkg::LEN_W-1:0]  wr_addr;

    assign in_left  = s_tdata[SB-1:0];
    assign in_right = s_tdata[2*SB-1:SB];
    assign s_tready = stage_ready;
    assign in_fire  = s_tvalid && stage_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bar_sync  <= 1'b1;
            cfg_reg.skip_bars <= '0;
            cfg_reg.gain      <= bsal_pkg::GAIN_UNITY;
            cfg_reg.reverse   <= 1'b0;
            cfg_reg.capacity  <= bsal_pkg::CAPACITY_INIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bsal_pkg::REG_BAR_SYNC:  cfg_reg.bar_sync  <= cfg_wdata[0];
                bsal_pkg::REG_SKIP_BARS: cfg_reg.skip_bars <= cfg_wdata[bsal_pkg::SKIP_W-1:0];
                bsal_pkg::REG_GAIN:      cfg_reg.gain      <= cfg_wdata[bsal_pkg::GAIN_W-1:0];
                bsal_pkg::REG_REVERSE:   cfg_reg.reverse   <= cfg_wdata[0];
                bsal_pkg::REG_CAPACITY:  cfg_reg.capacity  <= cfg_wdata[bsal_pkg::LEN_W-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    bsal_ctrl #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .mode      (s_tuser),
        .bar       (s_tdata[2*SB]),
        .run       (s_tdata[2*SB+1]),
        .new_state (s_tdata[2*SB+4:2*SB+2]),
        .cfg       (cfg_reg),
        .op        (op)
    );

    bsal_ram #(
        .WIDTH(2*SB),
        .DEPTH(MAX_FRAMES)
    ) u_loop_mem (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (ADDR_W'(wr_addr)),
        .wdata (wr_data),
        .re    (in_fire),
        .raddr (ADDR_W'(op.addr)),
        .rdata (rd_data)
    );

    bsal_datapath #(
        .SAMPLE_BITS(SB),
        .OUT_W(OUT_W)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_op       (op),
        .in_left     (in_left),
        .in_right    (in_right),
        .gain        (cfg_reg.gain),
        .stage_ready (stage_ready),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// File: test/bar_synced_audio_looper_tb.sv
// self-checking testbench of the bar synced looper: predicted frames checked against the result stream
module bar_synced_audio_looper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB          = 24;
    localparam int MAXF        = 524288;
    localparam int MW          = bsal_pkg::MODE_W;
    localparam int STW         = bsal_pkg::STATE_W;
    localparam int LW          = bsal_pkg::LEN_W;
    localparam int SKW         = bsal_pkg::SKIP_W;
    localparam int GW          = bsal_pkg::GAIN_W;
    localparam int RIW         = bsal_pkg::REG_IDX_W;
    localparam int CW          = bsal_pkg::CFG_W;
    localparam int S_W         = ((2*SB+12)/8)*8;
    localparam int M_W         = ((2*SB+50)/8)*8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 4;

    localparam logic signed [SB-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SB-1:0] S_MIN = 24'sh800000;

    typedef struct packed {
        logic [MW-1:0]        mode;
        logic signed [SB-1:0] sl;
        logic signed [SB-1:0] sr;
        logic                 bar;
        logic                 run;
        logic [STW-1:0]       ns;
    } frame_in_t;

    typedef struct packed {
        logic signed [SB-1:0] pl;
        logic signed [SB-1:0] pr;
        logic [STW-1:0]       st;
        logic [LW-1:0]        hd;
        logic [LW-1:0]        rl;
    } frame_out_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_W-1:0]       s_tdata   = '0;
    logic [MW-1:0]        s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_W-1:0]       m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [RIW-1:0]       cfg_index = '0;
    logic [CW-1:0]        cfg_wdata = '0;

    bar_synced_audio_looper i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    frame_in_t  queued_frames[$];
    frame_out_t predicted_outputs[$];
    frame_out_t awaited_outputs[$];
    frame_in_t  drive_frame;
    frame_out_t seen_out;
    frame_out_t want_out;

    int error_count    = 0;
    int result_index   = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int armed_bar_pct  = 30;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    // looper model state
    logic signed [SB-1:0] loop_l [0:MAXF-1];
    logic signed [SB-1:0] loop_r [0:MAXF-1];
    bit                   frame_written [0:MAXF-1];
    logic [STW-1:0]       lp_state  = bsal_pkg::ST_IDLE;
    logic [LW-1:0]        lp_head   = '0;
    logic [LW-1:0]        lp_rep    = '0;
    logic [LW-1:0]        lp_frames = '0;
    int                   lp_od_start = -1;
    logic [SKW-1:0]       lp_beats  = '0;

    logic                 cfg_bar_sync = 1'b1;
    logic [SKW-1:0]       cfg_skip     = '0;
    logic [GW-1:0]        cfg_gain     = bsal_pkg::GAIN_UNITY;
    logic                 cfg_reverse  = 1'b0;
    logic [LW-1:0]        cfg_cap      = bsal_pkg::CAPACITY_INIT;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bar_synced_audio_looper_tb: errors");
            $finish;
        end
    end

    function automatic logic signed [SB-1:0] clamp(input longint v);
        if (v > longint'(S_MAX)) return S_MAX;
        if (v < longint'(S_MIN)) return S_MIN;
        return v[SB-1:0];
    endfunction

    function automatic logic signed [SB-1:0] scale_sample(input logic signed [SB-1:0] s);
        longint p;
        longint g;
        g = longint'(cfg_gain);
        p = longint'(s);
        p = p * g + 64'sd8192;
        return clamp(p >>> 14);
    endfunction

    function automatic bit chance(input int pct);
        return int'($urandom_range(0, 99)) < pct;
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 19))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return 24'hFFFFFF;
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic frame_in_t cmd_frame(input logic [STW-1:0] ns);
        frame_in_t f;
        f.mode = bsal_pkg::MODE_CMD;
        f.sl   = rand_sample();
        f.sr   = rand_sample();
        f.bar  = 1'($urandom_range(0, 1));
        f.run  = 1'($urandom_range(0, 1));
        f.ns   = ns;
        return f;
    endfunction

    function automatic frame_in_t tick_frame(input logic signed [SB-1:0] l,
                                             input logic signed [SB-1:0] r,
                                             input logic bar, input logic run);
        frame_in_t f;
        f.mode = bsal_pkg::MODE_TICK;
        f.sl   = l;
        f.sr   = r;
        f.bar  = bar;
        f.run  = run;
        f.ns   = STW'($urandom_range(0, 7));
        return f;
    endfunction

    task automatic store_frame(input int idx, input logic signed [SB-1:0] l,
                               input logic signed [SB-1:0] r);
        loop_l[idx] = l;
        loop_r[idx] = r;
        frame_written[idx] = 1'b1;
    endtask

    task automatic record_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                                input int cap);
        if (int'(lp_head) < cap) begin
            store_frame(int'(lp_head), l, r);
            lp_head = lp_head + LW'(1);
        end
        lp_rep = lp_head;
    endtask

    task automatic close_loop();
        lp_frames = lp_head;
        lp_rep    = lp_head;
        lp_state  = bsal_pkg::ST_PLAY;
        lp_head   = '0;
    endtask

    task automatic step_looper(input frame_in_t f, output frame_out_t res);
        int cap;
        int len;
        int h;
        int ri;
        int prev;
        longint a;
        longint b;
        logic signed [SB-1:0] ol;
        logic signed [SB-1:0] orr;
        ol  = '0;
        orr = '0;
        cap = (int'(cfg_cap) > MAXF) ? MAXF : int'(cfg_cap);
        case (f.mode)
            bsal_pkg::MODE_TICK: begin
                case (lp_state)
                    bsal_pkg::ST_ARMED: begin
                        if (!cfg_bar_sync || (f.run && f.bar && lp_beats >= cfg_skip)) begin
                            lp_state = bsal_pkg::ST_REC;
                            lp_head  = '0;
                            lp_rep   = '0;
                            record_frame(f.sl, f.sr, cap);
                        end else if (f.run && f.bar) begin
                            lp_beats = lp_beats + SKW'(1);
                        end
                    end
                    bsal_pkg::ST_REC: begin
                        if (int'(lp_head) >= cap) close_loop();
                        else record_frame(f.sl, f.sr, cap);
                    end
                    bsal_pkg::ST_STOP: begin
                        if (int'(lp_head) >= cap || f.bar) close_loop();
                        else record_frame(f.sl, f.sr, cap);
                    end
                    bsal_pkg::ST_PLAY, bsal_pkg::ST_OVDB: begin
                        len = int'(lp_frames);
                        if (len != 0) begin
                            h    = (int'(lp_head) < len) ? int'(lp_head) : 0;
                            ri   = cfg_reverse ? (len - 1 - h) : h;
                            ol   = scale_sample(loop_l[ri]);
                            orr  = scale_sample(loop_r[ri]);
                            prev = h;
                            h    = (h + 1 == len) ? 0 : h + 1;
                            if (lp_state == bsal_pkg::ST_OVDB) begin
                                a = longint'(loop_l[ri]);
                                b = longint'(f.sl);
                                loop_l[ri] = clamp(a + b);
                                a = longint'(loop_r[ri]);
                                b = longint'(f.sr);
                                loop_r[ri] = clamp(a + b);
                                if (lp_od_start >= 0 && prev > len / 2 && h <= lp_od_start + 1)
                                    lp_state = bsal_pkg::ST_PLAY;
                            end
                            lp_head = LW'(h);
                        end
                    end
                    default: ;
                endcase
            end
            bsal_pkg::MODE_CMD: begin
                if (f.ns <= bsal_pkg::ST_OVDB) begin
                    if (f.ns == bsal_pkg::ST_ARMED) begin
                        lp_head   = '0;
                        lp_rep    = '0;
                        lp_frames = '0;
                        lp_beats  = '0;
                    end
                    if (f.ns == bsal_pkg::ST_PLAY && lp_state == bsal_pkg::ST_REC
                        && cfg_bar_sync) begin
                        lp_state = bsal_pkg::ST_STOP;
                    end else begin
                        if (f.ns == bsal_pkg::ST_PLAY && lp_state == bsal_pkg::ST_REC) begin
                            lp_frames = lp_head;
                            lp_rep    = lp_head;
                            lp_head   = '0;
                        end
                        if (f.ns == bsal_pkg::ST_OVDB) lp_od_start = int'(lp_head);
                        if (f.ns == bsal_pkg::ST_IDLE) begin
                            lp_head     = '0;
                            lp_od_start = -1;
                        end
                        lp_state = f.ns;
                    end
                end
            end
            bsal_pkg::MODE_CLEAR: begin
                lp_head     = '0;
                lp_rep      = '0;
                lp_frames   = '0;
                lp_od_start = -1;
            end
            default: ;
        endcase
        res.pl = ol;
        res.pr = orr;
        res.st = lp_state;
        res.hd = lp_head;
        res.rl = lp_rep;
    endtask

    task automatic queue_frame(input frame_in_t f);
        frame_out_t res;
        step_looper(f, res);
        queued_frames.push_back(f);
        predicted_outputs.push_back(res);
    endtask

    task automatic choose_next_frame(output frame_in_t f);
        int r;
        int len;
        int h;
        int ri;
        r = int'($urandom_range(0, 99));
        f = tick_frame(rand_sample(), rand_sample(), chance(25), chance(90));
        if (lp_state == bsal_pkg::ST_ARMED) begin
            f.bar = chance(armed_bar_pct);
            f.run = chance(armed_bar_pct);
        end else if (r < 8) begin
            f.mode = MW'($urandom_range(0, 3));
        end else begin
            case (lp_state)
                bsal_pkg::ST_IDLE: begin
                    if (r < 70) f = cmd_frame(bsal_pkg::ST_ARMED);
                    else if (r < 80) f = cmd_frame(bsal_pkg::ST_REC);
                end
                bsal_pkg::ST_REC: begin
                    if (r < 25) f = cmd_frame(bsal_pkg::ST_PLAY);
                    else if (r < 28) f.mode = bsal_pkg::MODE_CMD;
                end
                bsal_pkg::ST_PLAY: begin
                    if (r < 14) f = cmd_frame(bsal_pkg::ST_OVDB);
                    else if (r < 17) f = cmd_frame(bsal_pkg::ST_ARMED);
                    else if (r < 19) f.mode = bsal_pkg::MODE_CLEAR;
                    else if (r < 21) f = cmd_frame(bsal_pkg::ST_IDLE);
                    else if (r < 23) f = cmd_frame(bsal_pkg::ST_REC);
                    else if (r < 25) f = cmd_frame(bsal_pkg::ST_STOP);
                end
                bsal_pkg::ST_OVDB: begin
                    if (r < 12) f.mode = bsal_pkg::MODE_CMD;
                end
                default: ;
            endcase
        end
        // never play back a memory entry that was not recorded
        if (f.mode == bsal_pkg::MODE_TICK &&
            (lp_state == bsal_pkg::ST_PLAY || lp_state == bsal_pkg::ST_OVDB) &&
            lp_frames != 0) begin
            len = int'(lp_frames);
            h   = (int'(lp_head) < len) ? int'(lp_head) : 0;
            ri  = cfg_reverse ? (len - 1 - h) : h;
            if (!frame_written[ri]) f = cmd_frame(bsal_pkg::ST_ARMED);
        end
    endtask

    task automatic gen_random(input int n);
        frame_in_t f;
        repeat (n) begin
            choose_next_frame(f);
            queue_frame(f);
        end
    endtask

    task automatic write_reg(input logic [RIW-1:0] idx, input logic [CW-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            bsal_pkg::REG_BAR_SYNC:  cfg_bar_sync = val[0];
            bsal_pkg::REG_SKIP_BARS: cfg_skip     = val[SKW-1:0];
            bsal_pkg::REG_GAIN:      cfg_gain     = val[GW-1:0];
            bsal_pkg::REG_REVERSE:   cfg_reverse  = val[0];
            bsal_pkg::REG_CAPACITY:  cfg_cap      = val[LW-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (queued_frames.size() != 0 || predicted_outputs.size() != 0 ||
               awaited_outputs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic start_phase(input logic bs, input int skip, input int gain, input logic rev,
                               input int cap, input int sidle, input int rstall, input int abar);
        wait_drained();
        write_reg(bsal_pkg::REG_BAR_SYNC, CW'(bs));
        write_reg(bsal_pkg::REG_SKIP_BARS, CW'(skip));
        write_reg(bsal_pkg::REG_GAIN, CW'(gain));
        write_reg(bsal_pkg::REG_REVERSE, CW'(rev));
        write_reg(bsal_pkg::REG_CAPACITY, CW'(cap));
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        send_idle_pct  <= sidle;
        recv_stall_pct <= rstall;
        armed_bar_pct   = abar;
    endtask

    task automatic report_mismatch(input string what, input int idx, input longint got,
                                   input longint want);
        $display("mismatch at result %0d, %s: got %0d, want %0d", idx, what, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                awaited_outputs.push_back(predicted_outputs.pop_front());
            if (!s_tvalid || s_tready) begin
                if (queued_frames.size() != 0 &&
                    int'($urandom_range(0, 99)) >= send_idle_pct) begin
                    drive_frame = queued_frames.pop_front();
                    s_tdata  <= {3'b000, drive_frame.ns, drive_frame.run, drive_frame.bar,
                                 drive_frame.sr, drive_frame.sl};
                    s_tuser  <= drive_frame.mode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready    <= 1'b0;
            hold_left   <= LONG_HOLD;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_out.pl = m_tdata[23:0];
            seen_out.pr = m_tdata[47:24];
            seen_out.st = m_tdata[50:48];
            seen_out.hd = m_tdata[70:51];
            seen_out.rl = m_tdata[90:71];
            if (awaited_outputs.size() == 0) begin
                report_mismatch("unexpected item", result_index, 0, 0);
            end else begin
                want_out = awaited_outputs.pop_front();
                if (seen_out.pl !== want_out.pl)
                    report_mismatch("play_left", result_index, longint'(seen_out.pl),
                                    longint'(want_out.pl));
                if (seen_out.pr !== want_out.pr)
                    report_mismatch("play_right", result_index, longint'(seen_out.pr),
                                    longint'(want_out.pr));
                if (seen_out.st !== want_out.st)
                    report_mismatch("loop_state", result_index, longint'(seen_out.st),
                                    longint'(want_out.st));
                if (seen_out.hd !== want_out.hd)
                    report_mismatch("head_position", result_index, longint'(seen_out.hd),
                                    longint'(want_out.hd));
                if (seen_out.rl !== want_out.rl)
                    report_mismatch("recorded_length", result_index, longint'(seen_out.rl),
                                    longint'(want_out.rl));
            end
            result_index++;
        end
    end

    initial begin
        frame_in_t f;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        start_phase(1'b1, 0, int'(bsal_pkg::GAIN_UNITY), 1'b0, int'(bsal_pkg::CAPACITY_INIT),
                    0, 0, 30);
        // idle tick, ignored mode and requests, then a synced record, stop, overdub, clear and idle
        queue_frame(tick_frame(S_MAX, S_MIN, 1'b1, 1'b1));
        f = '1;
        queue_frame(f);
        queue_frame(cmd_frame(3'd7));
        queue_frame(cmd_frame(3'd6));
        queue_frame(cmd_frame(bsal_pkg::ST_ARMED));
        queue_frame(tick_frame(24'sd1, 24'sd1, 1'b1, 1'b0));
        queue_frame(tick_frame(24'sd2, 24'sd2, 1'b0, 1'b1));
        queue_frame(tick_frame(S_MAX, S_MIN, 1'b1, 1'b1));
        queue_frame(tick_frame(S_MIN, S_MAX, 1'b0, 1'b0));
        queue_frame(tick_frame(24'sd1, 24'hFFFFFF, 1'b1, 1'b1));
        queue_frame(cmd_frame(bsal_pkg::ST_PLAY));
        queue_frame(tick_frame(24'hFFFFFF, 24'sd1, 1'b0, 1'b1));
        queue_frame(tick_frame(24'sd5, 24'sd5, 1'b1, 1'b1));
        repeat (5) queue_frame(tick_frame('0, '0, 1'b0, 1'b1));
        queue_frame(cmd_frame(bsal_pkg::ST_OVDB));
        repeat (6) queue_frame(tick_frame(S_MAX, S_MIN, 1'b0, 1'b1));
        f = cmd_frame(bsal_pkg::ST_IDLE);
        f.mode = bsal_pkg::MODE_CLEAR;
        queue_frame(f);
        queue_frame(cmd_frame(bsal_pkg::ST_IDLE));
        gen_random(20);

        start_phase(1'b0, 0, 0, 1'b1, 1, 64, 0, 30);
        gen_random(40);

        start_phase(1'b1, 3, 65535, 1'b0, 16, 0, 64, 30);
        gen_random(80);
        while (queued_frames.size() > 40) @(posedge aclk);
        hold_requests <= hold_requests + 1;

        start_phase(1'b0, 255, int'(bsal_pkg::GAIN_UNITY), 1'b1, 1048575, 25, 25, 30);
        gen_random(60);

        start_phase(1'b1, 255, 12000, 1'b0, 40, 0, 0, 97);
        gen_random(340);

        start_phase(1'($urandom_range(0, 1)), int'($urandom_range(0, 4)),
                    int'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    int'($urandom_range(1, 64)), 25, 25, 40);
        gen_random(20);

        start_phase(1'($urandom_range(0, 1)), int'($urandom_range(0, 4)),
                    int'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    int'($urandom_range(1, 64)), 64, 0, 40);
        gen_random(20);

        wait_drained();
        if (error_count == 0) begin
            $display("bar_synced_audio_looper_tb: clean");
        end else begin
            $display("bar_synced_audio_looper_tb: errors");
        end
        $finish;
    end

endmodule

// File: files.f
design/bsal_pkg.sv
design/bsal_ram.sv
design/bsal_ctrl.sv
design/bsal_datapath.sv
design/bar_synced_audio_looper.sv
test/bar_synced_audio_looper_tb.sv
